/* hw/rtl/order_book_table_assert.svh */
// Assertion macros shared by the order book table RTL.
`ifndef ORDER_BOOK_TABLE_ASSERT_SVH
`define ORDER_BOOK_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a condition at every clock edge outside reset.
`define OBT_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
// Check that a trigger is followed by a condition in the next cycle.
`define OBT_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);
`else
`define OBT_ASSERT_ALWAYS(label, cond, msg)
`define OBT_ASSERT_NEXT(label, trig, cond, msg)
`endif
`endif

/* hw/rtl/obt_pkg.sv */
// Package with the shared types of the order book table.
`timescale 1ns / 1ps
package obt_pkg;

   typedef enum logic [1:0] {
      REQ_ADD      = 2'd0,
      REQ_REMOVE   = 2'd1,
      REQ_LOOKUP   = 2'd2,
      REQ_RESERVED = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_NOT_FOUND = 2'd1,
      STS_DUPLICATE = 2'd2,
      STS_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_WIPE,
      S_IDLE,
      S_SCAN,
      S_MERGE,
      S_FINISH
   } state_type;

   // Sequencer strobes toward the datapath.
   typedef struct packed {
      logic wipe;    // clearing pass writes one entry
      logic clear;   // reset the scan accumulators
      logic step;    // one entry enters the compare unit
      logic merge;   // the entry is the new order of an add
      logic finish;  // commit the write and load the response
      logic busy;    // no request taken
   } seq_type;

endpackage

/* hw/rtl/obt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module obt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/obt_ctrl.sv */
// Sequencer of the order book table: clearing pass, table scan, merge, finish.
`timescale 1ns / 1ps
module obt_ctrl #(
   parameter int MAX_ORDERS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_fire,
   input  logic                          rsp_free,
   output obt_pkg::seq_type              seq,
   output logic [$clog2(MAX_ORDERS)-1:0] addr,
   output logic [$clog2(MAX_ORDERS)-1:0] data_idx
);
   import obt_pkg::*;

   localparam int AW = $clog2(MAX_ORDERS);
   localparam int CW = $clog2(MAX_ORDERS + 1);
   localparam logic [CW-1:0] LAST = CW'(MAX_ORDERS - 1);
   localparam logic [CW-1:0] ENDS = CW'(MAX_ORDERS);

   state_type      state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [AW-1:0]  idx_ff, idx_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_WIPE: begin
            if (cnt_ff == LAST) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (cnt_ff == ENDS) state_in = S_MERGE;
         end
         S_MERGE: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Entry counter; advance one entry a cycle.
   always_comb begin
      cnt_in = cnt_ff;
      case (state_ff)
         S_WIPE: begin
            cnt_in = (cnt_ff == LAST) ? '0 : cnt_ff + 1'b1;
         end
         S_IDLE: begin
            cnt_in = '0;
         end
         S_SCAN: begin
            cnt_in = (cnt_ff == ENDS) ? '0 : cnt_ff + 1'b1;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
      idx_in = cnt_ff[AW-1:0];
   end

   // Outputs.
   always_comb begin
      seq = '0;
      case (state_ff)
         S_WIPE: begin
            seq.wipe = 1'b1;
            seq.busy = 1'b1;
         end
         S_IDLE: begin
            seq.clear = req_fire;
         end
         S_SCAN: begin
            seq.busy = 1'b1;
            seq.step = (cnt_ff != '0);
         end
         S_MERGE: begin
            seq.busy  = 1'b1;
            seq.step  = 1'b1;
            seq.merge = 1'b1;
         end
         S_FINISH: begin
            seq.busy   = 1'b1;
            seq.finish = rsp_free;
         end
         default: begin
            seq.busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WIPE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      idx_ff <= idx_in;
   end

   assign addr     = cnt_ff[AW-1:0];
   assign data_idx = idx_ff;

endmodule

/* hw/rtl/obt_scan.sv */
// Scan accumulator: id match, first free slot and shared best-price compare.
`timescale 1ns / 1ps
module obt_scan #(
   parameter int MAX_ORDERS = 256,
   parameter int PRICE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  obt_pkg::seq_type              seq,
   input  logic                          e_valid,
   input  logic                          e_side,
   input  logic [31:0]                   e_id,
   input  logic [PRICE_BITS-1:0]         e_price,
   input  logic [$clog2(MAX_ORDERS)-1:0] e_idx,
   input  obt_pkg::req_kind_type         kind,
   input  logic [31:0]                   req_id,
   output logic                          match,
   output logic [$clog2(MAX_ORDERS)-1:0] match_idx,
   output logic                          found_side,
   output logic [PRICE_BITS-1:0]         found_price,
   output logic                          free_found,
   output logic [$clog2(MAX_ORDERS)-1:0] free_idx,
   output logic [PRICE_BITS-1:0]         bid,
   output logic                          have_bid,
   output logic [PRICE_BITS-1:0]         ask,
   output logic                          have_ask
);
   import obt_pkg::*;

   localparam int AW = $clog2(MAX_ORDERS);

   logic                  match_ff, match_in;
   logic [AW-1:0]         match_idx_ff, match_idx_in;
   logic                  fside_ff, fside_in;
   logic [PRICE_BITS-1:0] fprice_ff, fprice_in;
   logic                  free_ff, free_in;
   logic [AW-1:0]         free_idx_ff, free_idx_in;
   logic [PRICE_BITS-1:0] bid_ff, bid_in, ask_ff, ask_in;
   logic                  have_bid_ff, have_bid_in, have_ask_ff, have_ask_in;

   logic                  hit, keep, have, better, take;
   logic [PRICE_BITS-1:0] cur;

   // One compare serves both sides: greater for buys, less for sells.
   always_comb begin
      hit    = e_valid && (e_id == req_id) && !seq.merge;
      keep   = e_valid && !(hit && (kind == REQ_REMOVE));
      cur    = e_side ? ask_ff : bid_ff;
      have   = e_side ? have_ask_ff : have_bid_ff;
      better = e_side ? (e_price < cur) : (e_price > cur);
      take   = seq.step && keep && (!have || better);
   end

   always_comb begin
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      fside_in     = fside_ff;
      fprice_in    = fprice_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      bid_in       = bid_ff;
      ask_in       = ask_ff;
      have_bid_in  = have_bid_ff;
      have_ask_in  = have_ask_ff;
      if (seq.clear) begin
         match_in    = 1'b0;
         free_in     = 1'b0;
         bid_in      = '0;
         ask_in      = '0;
         have_bid_in = 1'b0;
         have_ask_in = 1'b0;
      end else if (seq.step) begin
         if (take && e_side) begin
            ask_in      = e_price;
            have_ask_in = 1'b1;
         end
         if (take && !e_side) begin
            bid_in      = e_price;
            have_bid_in = 1'b1;
         end
         if (hit) begin
            match_in     = 1'b1;
            match_idx_in = e_idx;
            fside_in     = e_side;
            fprice_in    = e_price;
         end
         if (!seq.merge && !e_valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = e_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff    <= 1'b0;
         free_ff     <= 1'b0;
         have_bid_ff <= 1'b0;
         have_ask_ff <= 1'b0;
      end else begin
         match_ff    <= match_in;
         free_ff     <= free_in;
         have_bid_ff <= have_bid_in;
         have_ask_ff <= have_ask_in;
      end
      match_idx_ff <= match_idx_in;
      fside_ff     <= fside_in;
      fprice_ff    <= fprice_in;
      free_idx_ff  <= free_idx_in;
      bid_ff       <= bid_in;
      ask_ff       <= ask_in;
   end

   assign match       = match_ff;
   assign match_idx   = match_idx_ff;
   assign found_side  = fside_ff;
   assign found_price = fprice_ff;
   assign free_found  = free_ff;
   assign free_idx    = free_idx_ff;
   assign bid         = bid_ff;
   assign have_bid    = have_bid_ff;
   assign ask         = ask_ff;
   assign have_ask    = have_ask_ff;

endmodule

/* hw/rtl/order_book_table.sv */
// Top level of the order book table: request/response ports, entry RAM, sequencer.
`timescale 1ns / 1ps
`include "order_book_table_assert.svh"
// Resting-order table of MAX_ORDERS slots kept in one single-port-write RAM.
// Each request (add, remove, look up by order id) is accepted, then the
// table is swept one entry per cycle through the RAM read port, a newly
// added order is folded into the best prices, and the table write is
// committed and the response register loaded. req_stall stays high for
// the whole request; a response waiting in the output register does not
// hold up the next request until that request is ready to finish. After
// reset a clearing pass zeroes every entry's valid bit with req_stall
// high. Best bid is the highest resting buy price and best ask the lowest
// resting sell price, both taken after the request; an empty side reads 0
// with its valid flag low. Prices wider than 32 bits are truncated on the
// response ports; narrower ones keep only their low PRICE_BITS bits.
module order_book_table #(
   parameter int MAX_ORDERS = 256,
   parameter int PRICE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request beat
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_order_id,
   input  logic        req_order_side,
   input  logic [31:0] req_order_price,
   // response beat
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_found_side,
   output logic [31:0] rsp_found_price,
   output logic [31:0] rsp_best_bid,
   output logic        rsp_bid_valid,
   output logic [31:0] rsp_best_ask,
   output logic        rsp_ask_valid
);
   import obt_pkg::*;

   localparam int AW         = $clog2(MAX_ORDERS);
   // Entry word: {valid, side, price, id}.
   localparam int ENTRY_BITS = PRICE_BITS + 34;

   seq_type seq;
   logic [AW-1:0] seq_addr, data_idx;
   logic req_fire, rsp_free;

   // Request held for the whole sweep.
   req_kind_type          req_kind_ff, req_kind_in;
   logic [31:0]           req_id_ff, req_id_in;
   logic                  req_side_ff, req_side_in;
   logic [PRICE_BITS-1:0] req_price_ff, req_price_in;

   // Entry RAM ports.
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [ENTRY_BITS-1:0] wr_data, rd_data;

   // Scan unit inputs and results.
   logic                  e_valid, e_side;
   logic [31:0]           e_id;
   logic [PRICE_BITS-1:0] e_price;
   logic                  match, free_found, found_side, have_bid, have_ask;
   logic [AW-1:0]         match_idx, free_idx;
   logic [PRICE_BITS-1:0] found_price, bid, ask;
   logic                  add_ok, rem_ok;

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  status_ff, status_in;
   logic        fside_ff, fside_in;
   logic [31:0] fprice_ff, fprice_in;
   logic [31:0] bid_ff, bid_in, ask_ff, ask_in;
   logic        bid_valid_ff, bid_valid_in, ask_valid_ff, ask_valid_in;

   assign req_stall = seq.busy;
   assign req_fire  = req_valid && !req_stall;
   // The response slot can take a new result when empty or being drained.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   obt_ctrl #(
      .MAX_ORDERS (MAX_ORDERS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .rsp_free (rsp_free),
      .seq      (seq),
      .addr     (seq_addr),
      .data_idx (data_idx)
   );

   // Capture the request beat.
   always_comb begin
      req_kind_in  = req_kind_ff;
      req_id_in    = req_id_ff;
      req_side_in  = req_side_ff;
      req_price_in = req_price_ff;
      if (req_fire) begin
         req_kind_in  = req_kind_type'(req_type);
         req_id_in    = req_order_id;
         req_side_in  = req_order_side;
         req_price_in = PRICE_BITS'(64'(req_order_price));
      end
   end

   always_ff @(posedge clock) begin
      req_kind_ff  <= req_kind_in;
      req_id_ff    <= req_id_in;
      req_side_ff  <= req_side_in;
      req_price_ff <= req_price_in;
   end

   // An add stores only when the id is new and a slot is free; a remove
   // drops the matching entry.
   assign add_ok = (req_kind_ff == REQ_ADD) && !match && free_found;
   assign rem_ok = (req_kind_ff == REQ_REMOVE) && match;

   // Write the clearing pass, or commit the request at finish.
   always_comb begin
      wr_en   = seq.wipe || (seq.finish && (add_ok || rem_ok));
      wr_addr = seq_addr;
      wr_data = '0;
      if (!seq.wipe && add_ok) begin
         wr_addr = free_idx;
         wr_data = {1'b1, req_side_ff, req_price_ff, req_id_ff};
      end else if (!seq.wipe) begin
         wr_addr = match_idx;
      end
   end

   obt_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_ORDERS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (seq_addr),
      .rd_data (rd_data)
   );

   // During merge the new order of an add enters the compare unit in place
   // of a table entry.
   always_comb begin
      if (seq.merge) begin
         e_valid = add_ok;
         e_side  = req_side_ff;
         e_id    = req_id_ff;
         e_price = req_price_ff;
      end else begin
         e_valid = rd_data[ENTRY_BITS-1];
         e_side  = rd_data[ENTRY_BITS-2];
         e_id    = rd_data[31:0];
         e_price = rd_data[32 +: PRICE_BITS];
      end
   end

   obt_scan #(
      .MAX_ORDERS (MAX_ORDERS),
      .PRICE_BITS (PRICE_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .seq         (seq),
      .e_valid     (e_valid),
      .e_side      (e_side),
      .e_id        (e_id),
      .e_price     (e_price),
      .e_idx       (data_idx),
      .kind        (req_kind_ff),
      .req_id      (req_id_ff),
      .match       (match),
      .match_idx   (match_idx),
      .found_side  (found_side),
      .found_price (found_price),
      .free_found  (free_found),
      .free_idx    (free_idx),
      .bid         (bid),
      .have_bid    (have_bid),
      .ask         (ask),
      .have_ask    (have_ask)
   );

   // Build the response; hold it until the beat is taken.
   always_comb begin
      rsp_valid_in = seq.finish || (rsp_valid_ff && rsp_stall);
      status_in    = status_ff;
      fside_in     = fside_ff;
      fprice_in    = fprice_ff;
      bid_in       = bid_ff;
      ask_in       = ask_ff;
      bid_valid_in = bid_valid_ff;
      ask_valid_in = ask_valid_ff;
      if (seq.finish) begin
         status_in = STS_OK;
         fside_in  = 1'b0;
         fprice_in = '0;
         case (req_kind_ff)
            REQ_ADD: begin
               if (match) begin
                  status_in = STS_DUPLICATE;
               end else if (!free_found) begin
                  status_in = STS_FULL;
               end
            end
            REQ_REMOVE, REQ_LOOKUP: begin
               if (match) begin
                  fside_in  = found_side;
                  fprice_in = 32'(64'(found_price));
               end else begin
                  status_in = STS_NOT_FOUND;
               end
            end
            default: begin
               status_in = STS_OK;
            end
         endcase
         bid_in       = 32'(64'(bid));
         ask_in       = 32'(64'(ask));
         bid_valid_in = have_bid;
         ask_valid_in = have_ask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff    <= status_in;
      fside_ff     <= fside_in;
      fprice_ff    <= fprice_in;
      bid_ff       <= bid_in;
      ask_ff       <= ask_in;
      bid_valid_ff <= bid_valid_in;
      ask_valid_ff <= ask_valid_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found_side  = fside_ff;
   assign rsp_found_price = fprice_ff;
   assign rsp_best_bid    = bid_ff;
   assign rsp_bid_valid   = bid_valid_ff;
   assign rsp_best_ask    = ask_ff;
   assign rsp_ask_valid   = ask_valid_ff;

   // An accepted request keeps the input side stalled on the next cycle.
   `OBT_ASSERT_NEXT(a_accept_busy, req_fire, req_stall, "request accepted but block not busy")
   // Finishing a request always leaves a response pending.
   `OBT_ASSERT_NEXT(a_finish_load, seq.finish, rsp_valid, "finish did not load the response")
   // Table writes come only from the clearing pass or a finishing request.
   `OBT_ASSERT_ALWAYS(a_write_src, !wr_en || seq.wipe || seq.finish, "stray table write")
   // A finished add never both stores and reports a duplicate.
   `OBT_ASSERT_ALWAYS(a_add_dup, !(seq.finish && add_ok && match), "duplicate add stored")

endmodule

/* test/tb_order_book_table.sv */
// Self-checking testbench for the order book table: random and directed order traffic.
`timescale 1ns / 1ps
module tb_order_book_table;
   import obt_pkg::*;

   localparam int BOOK_SLOTS   = 256;
   localparam int ORDER_COUNT  = 1400;
   localparam int CALM_ORDERS  = 150;                  // tail of the run without idling
   localparam int HOLD_CYCLES  = 2000;                 // long receiver hold-off
   localparam int HOLD_AFTER   = 40;                   // requests taken before the hold-off
   localparam int DRAIN_CYCLES = 2 * (BOOK_SLOTS + 3) + 20;
   localparam int IDLE_LIMIT   = 10000;                // cycles with no beat on either side

   typedef struct packed {
      req_kind_type kind;
      logic [31:0]  id;
      logic         side;
      logic [31:0]  price;
   } book_order_type;

   typedef struct packed {
      status_type  status;
      logic        found_side;
      logic [31:0] found_price;
      logic [31:0] best_bid;
      logic        bid_valid;
      logic [31:0] best_ask;
      logic        ask_valid;
   } book_quote_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = 2'd0;
   logic [31:0] req_order_id = 32'd0;
   logic        req_order_side = 1'b0;
   logic [31:0] req_order_price = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_found_side;
   logic [31:0] rsp_found_price;
   logic [31:0] rsp_best_bid;
   logic        rsp_bid_valid;
   logic [31:0] rsp_best_ask;
   logic        rsp_ask_valid;

   // Shadow of the resting orders, advanced once per accepted request.
   logic        book_live  [BOOK_SLOTS];
   logic [31:0] book_id    [BOOK_SLOTS];
   logic        book_side  [BOOK_SLOTS];
   logic [31:0] book_price [BOOK_SLOTS];

   book_order_type  pending_orders[$];   // requests still to be offered
   book_quote_type  book_quotes[$];      // expected responses, oldest first
   int unsigned     live_ids[$];         // ids resting in the book, as seen by the generator
   book_order_type  offered;             // request currently on the request port
   int              order_total = 0;
   int              orders_launched = 0;
   int              orders_taken = 0;
   int              quotes_checked = 0;
   int              fail_count = 0;
   int              gap_left = 0;
   int              stall_left = 0;
   int              hold_left = 0;
   logic            hold_done = 1'b0;
   logic            calm_phase = 1'b0;
   int              idle_cycles = 0;

   order_book_table i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_order_id    (req_order_id),
      .req_order_side  (req_order_side),
      .req_order_price (req_order_price),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found_side  (rsp_found_side),
      .rsp_found_price (rsp_found_price),
      .rsp_best_bid    (rsp_best_bid),
      .rsp_bid_valid   (rsp_bid_valid),
      .rsp_best_ask    (rsp_best_ask),
      .rsp_ask_valid   (rsp_ask_valid)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Apply one request to the shadow book and return the response it must produce.
   function automatic book_quote_type book_apply(input book_order_type o);
      book_quote_type q;
      int             i;
      int             hit;
      int             free_at;
      q = '0;
      q.status = STS_OK;
      hit = -1;
      free_at = -1;
      for (i = 0; i < BOOK_SLOTS; i++) begin
         if (book_live[i] && book_id[i] == o.id && hit < 0) hit = i;
         if (!book_live[i] && free_at < 0) free_at = i;
      end
      case (o.kind)
         REQ_ADD: begin
            // duplicate wins over full; a new order takes the lowest free slot
            if (hit >= 0) q.status = STS_DUPLICATE;
            else if (free_at < 0) q.status = STS_FULL;
            else begin
               book_live[free_at]  = 1'b1;
               book_id[free_at]    = o.id;
               book_side[free_at]  = o.side;
               book_price[free_at] = o.price;
            end
         end
         REQ_REMOVE, REQ_LOOKUP: begin
            if (hit < 0) q.status = STS_NOT_FOUND;
            else begin
               q.found_side  = book_side[hit];
               q.found_price = book_price[hit];
               if (o.kind == REQ_REMOVE) book_live[hit] = 1'b0;
            end
         end
         default: ;   // reserved kind leaves the book alone
      endcase
      // best prices after the request; an empty side reads 0 with its flag low
      for (i = 0; i < BOOK_SLOTS; i++) begin
         if (book_live[i]) begin
            if (book_side[i] == 1'b0) begin
               if (!q.bid_valid || book_price[i] > q.best_bid) q.best_bid = book_price[i];
               q.bid_valid = 1'b1;
            end else begin
               if (!q.ask_valid || book_price[i] < q.best_ask) q.best_ask = book_price[i];
               q.ask_valid = 1'b1;
            end
         end
      end
      return q;
   endfunction

   function automatic int live_index(input int unsigned id);
      int i;
      for (i = 0; i < live_ids.size(); i++)
         if (live_ids[i] == id) return i;
      return -1;
   endfunction

   function automatic logic [31:0] pick_price();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2, 3:    return $urandom_range(100, 108);   // crowd a few levels to get ties
         default: return $urandom;
      endcase
   endfunction

   function automatic int unsigned fresh_id();
      int unsigned id;
      id = $urandom;
      while (live_index(id) >= 0) id = $urandom;
      return id;
   endfunction

   function automatic int unsigned resting_id();
      return live_ids[$urandom_range(0, live_ids.size() - 1)];
   endfunction

   // Queue one request and keep the generator's view of resting ids in step.
   task automatic queue_order(input req_kind_type kind, input logic [31:0] id,
                              input logic side, input logic [31:0] price);
      book_order_type o;
      int             idx;
      o.kind  = kind;
      o.id    = id;
      o.side  = side;
      o.price = price;
      pending_orders.insert(pending_orders.size(), o);
      idx = live_index(id);
      if (kind == REQ_ADD && idx < 0 && live_ids.size() < BOOK_SLOTS)
         live_ids.insert(live_ids.size(), id);
      if (kind == REQ_REMOVE && idx >= 0) live_ids.delete(idx);
   endtask

   // Mixed traffic: new orders, hits on resting ids, some misses, duplicates and noise.
   task automatic queue_mixed(input int count);
      int          n;
      int unsigned pick;
      int unsigned id;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            if (live_ids.size() != 0 && $urandom_range(0, 4) == 0) id = resting_id();
            else id = fresh_id();
            queue_order(REQ_ADD, id, 1'($urandom_range(0, 1)), pick_price());
         end else if (pick < 92) begin
            if (live_ids.size() != 0 && $urandom_range(0, 4) != 0) id = resting_id();
            else id = fresh_id();
            queue_order(pick < 65 ? REQ_REMOVE : REQ_LOOKUP, id, 1'($urandom_range(0, 1)),
                        $urandom);
         end else begin
            queue_order(REQ_RESERVED, $urandom, 1'($urandom_range(0, 1)), $urandom);
         end
      end
   endtask

   // Fill the book to the brim, knock on it while full, thin it out, then reuse a freed slot.
   task automatic queue_fill(input int keep);
      while (live_ids.size() < BOOK_SLOTS)
         queue_order(REQ_ADD, fresh_id(), 1'($urandom_range(0, 1)), pick_price());
      queue_order(REQ_ADD, fresh_id(), 1'($urandom_range(0, 1)), pick_price());
      queue_order(REQ_ADD, resting_id(), 1'($urandom_range(0, 1)), pick_price());
      queue_order(REQ_LOOKUP, resting_id(), 1'b0, 32'd0);
      queue_order(REQ_ADD, fresh_id(), 1'($urandom_range(0, 1)), pick_price());
      while (live_ids.size() > keep)
         queue_order(REQ_REMOVE, resting_id(), 1'b0, 32'd0);
      // a freed slot must be reusable
      queue_order(REQ_ADD, fresh_id(), 1'($urandom_range(0, 1)), pick_price());
   endtask

   initial begin : stimulus
      int i;
      for (i = 0; i < BOOK_SLOTS; i++) book_live[i] = 1'b0;

      // empty book: misses and a reserved request
      queue_order(REQ_LOOKUP,   32'h0000_0000, 1'b0, 32'h0000_0000);
      queue_order(REQ_REMOVE,   32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      queue_order(REQ_RESERVED, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      // extremes of id and price on both sides
      queue_order(REQ_ADD,      32'h0000_0000, 1'b0, 32'h0000_0000);
      queue_order(REQ_ADD,      32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      queue_order(REQ_ADD,      32'h0000_0001, 1'b0, 32'hFFFF_FFFF);
      queue_order(REQ_ADD,      32'h0000_0002, 1'b1, 32'h0000_0000);
      queue_order(REQ_ADD,      32'h0000_0000, 1'b1, 32'h1234_5678);   // duplicate id
      queue_order(REQ_LOOKUP,   32'hFFFF_FFFF, 1'b0, 32'h0000_0000);
      queue_order(REQ_LOOKUP,   32'h0000_0000, 1'b1, 32'hFFFF_FFFF);
      queue_order(REQ_RESERVED, 32'h0000_0002, 1'b0, 32'h8000_0000);
      queue_order(REQ_REMOVE,   32'h0000_0001, 1'b0, 32'h0000_0000);
      queue_order(REQ_REMOVE,   32'h0000_0001, 1'b0, 32'h0000_0000);   // already gone
      queue_order(REQ_LOOKUP,   32'h8000_0000, 1'b0, 32'h0000_0000);   // never added
      queue_order(REQ_REMOVE,   32'h0000_0002, 1'b1, 32'h0000_0000);
      queue_order(REQ_REMOVE,   32'hFFFF_FFFF, 1'b0, 32'h0000_0000);
      queue_order(REQ_REMOVE,   32'h0000_0000, 1'b0, 32'h0000_0000);   // book empty again
      queue_order(REQ_ADD,      32'h8000_0000, 1'b0, 32'h8000_0000);
      queue_order(REQ_ADD,      32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF);   // crossed book
      queue_order(REQ_ADD,      32'h5555_5555, 1'b0, 32'h8000_0000);   // same level
      queue_order(REQ_REMOVE,   32'h8000_0000, 1'b0, 32'h0000_0000);
      queue_order(REQ_LOOKUP,   32'h5555_5555, 1'b1, 32'h0000_0000);

      queue_mixed(250);
      queue_fill($urandom_range(64, 128));
      queue_mixed(50);
      while (live_ids.size() != 0) queue_order(REQ_REMOVE, resting_id(), 1'b0, 32'd0);
      queue_mixed(150);
      queue_fill($urandom_range(0, 32));
      if (pending_orders.size() < ORDER_COUNT)
         queue_mixed(ORDER_COUNT - pending_orders.size());
      order_total = pending_orders.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // wait for every response, then watch for strays before the verdict
      while (quotes_checked != order_total) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && book_quotes.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Request driver: predict on every accepted beat, hold the payload while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            book_quotes.insert(book_quotes.size(), book_apply(offered));
            orders_taken <= orders_taken + 1;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_orders.size() != 0) begin
               offered = pending_orders.pop_front();
               req_valid       <= 1'b1;
               req_type        <= offered.kind;
               req_order_id    <= offered.id;
               req_order_side  <= offered.side;
               req_order_price <= offered.price;
               orders_launched++;
               // drop all idling for the tail of the run
               if (orders_launched > order_total - CALM_ORDERS) calm_phase <= 1'b1;
               else if ($urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 10);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response stall: one long hold-off early on, random bursts until the tail.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && orders_taken >= HOLD_AFTER) begin
         // hold while the sender keeps offering, so the block backs up
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (calm_phase) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 9);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endtask

   // Response monitor: compare each beat with the oldest expected response.
   always @(posedge clock) begin : monitor
      book_quote_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         quotes_checked <= quotes_checked + 1;
         if (book_quotes.size() == 0) begin
            $error("response beat with no request outstanding");
            fail_count++;
         end else begin
            want = book_quotes.pop_front();
            check_field("status",      32'(want.status),     32'(rsp_status));
            check_field("found_side",  32'(want.found_side), 32'(rsp_found_side));
            check_field("found_price", want.found_price,     rsp_found_price);
            check_field("best_bid",    want.best_bid,        rsp_best_bid);
            check_field("bid_valid",   32'(want.bid_valid),  32'(rsp_bid_valid));
            check_field("best_ask",    want.best_ask,        rsp_best_ask);
            check_field("ask_valid",   32'(want.ask_valid),  32'(rsp_ask_valid));
         end
      end
   end

   // Watchdog: end the run when neither side moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule
